// File: hdl/ett_pkg.sv
package ett_pkg;

	localparam int SLOTS_DEF = 16;

	// operation codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_CREATE = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_EXPIRED = 2'd0;
	localparam logic [1:0] KIND_CLOCK   = 2'd1;
	localparam logic [1:0] KIND_REPLY   = 2'd2;

	// reply status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADARG  = 2'd3;

	// configuration register indexes
	localparam logic CFG_TASK_LIMIT  = 1'b0;
	localparam logic CFG_EVENT_LIMIT = 1'b1;

	localparam logic [8:0] LIMIT_RESET = 9'd256;
	localparam logic [10:0] MS_PER_SEC = 11'd1000;

	// per-cell control
	typedef struct packed {
		logic load;
		logic shift;
		logic dec;
	} cell_ctrl_t;

endpackage

// File: hdl/ett_in_if.sv
interface ett_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [7:0]  task_id;
	logic [7:0]  evt_id;
	logic [31:0] wait_ms;
	logic [7:0]  systick_now;

	modport source (output valid, operation, task_id, evt_id, wait_ms, systick_now,
		input ready);
	modport sink (input valid, operation, task_id, evt_id, wait_ms, systick_now,
		output ready);
endinterface

// File: hdl/ett_out_if.sv
interface ett_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  task_id_out;
	logic [7:0]  evt_id_out;
	logic [31:0] remaining_ms;
	logic [1:0]  status;
	logic [9:0]  clock_ms;
	logic [31:0] clock_sec;
	logic [31:0] sysclock_ms;
	logic        last;

	modport source (output valid, result_kind, task_id_out, evt_id_out, remaining_ms,
		status, clock_ms, clock_sec, sysclock_ms, last, input ready);
	modport sink (input valid, result_kind, task_id_out, evt_id_out, remaining_ms,
		status, clock_ms, clock_sec, sysclock_ms, last, output ready);
endinterface

// File: hdl/ett_cell.sv
module ett_cell (
	input  logic              clk,
	input  ett_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]        key_task,
	input  logic [7:0]        key_event,
	input  logic [31:0]       wr_rem,
	input  logic [7:0]        delta,
	input  logic [7:0]        nxt_task,
	input  logic [7:0]        nxt_event,
	input  logic [31:0]       nxt_rem,
	output logic [7:0]        task_q,
	output logic [7:0]        event_q,
	output logic [31:0]       rem_q,
	output logic              match,
	output logic              zero
);
	import ett_pkg::*;

	// key compare and expiry flag
	assign match = (task_q == key_task) && (event_q == key_event);
	assign zero  = (rem_q == 32'd0);

	// load, take neighbor's entry, or count down with saturation
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			task_q  <= key_task;
			event_q <= key_event;
			rem_q   <= wr_rem;
		end else if (ctrl.shift) begin
			task_q  <= nxt_task;
			event_q <= nxt_event;
			rem_q   <= nxt_rem;
		end else if (ctrl.dec) begin
			rem_q <= (rem_q >= {24'd0, delta}) ? rem_q - {24'd0, delta} : 32'd0;
		end
	end
endmodule

// File: hdl/event_timer_table.sv
// Commands: an accepted command moves to S_CMD, which registers the reply once the output
// is free. Tick: after the accept, S_DEC counts down across the cell chain, S_SCAN removes
// one expired timer per pass while the output is free (each removal shifts the chain by one
// cell), a scan that finds no expiry moves to S_STAT, which sends the clock status; a tick
// with unchanged systick goes straight to S_STAT. One item is in work at a time.
// Reset (arst_n low) empties the table, clears uptime and restores both limits to 256.
module event_timer_table #(
	parameter int SLOTS = ett_pkg::SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	ett_in_if.sink     in_ch,
	ett_out_if.source  out_ch
);
	import ett_pkg::*;

	localparam int CNTW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_CMD, S_DEC, S_SCAN, S_STAT} state_t;

	state_t      state_q;
	logic [8:0]  task_limit_q, event_limit_q;
	logic [CNTW-1:0] count_q;
	logic [7:0]  last_tick_q, delta_q;
	logic [9:0]  ms_q;
	logic [31:0] sec_q, total_q;
	logic [2:0]  op_q;
	logic [7:0]  task_q, event_q;
	logic [31:0] tmo_q;

	logic        ovld_q, olast_q;
	logic [1:0]  okind_q, ostat_q;
	logic [7:0]  otask_q, oevent_q;
	logic [31:0] orem_q, osec_q, osys_q;
	logic [9:0]  oms_q;

	cell_ctrl_t  ctrl [SLOTS];
	logic [7:0]  c_task [SLOTS];
	logic [7:0]  c_event [SLOTS];
	logic [31:0] c_rem [SLOTS];
	logic [SLOTS-1:0] c_match, c_zero, live, app;
	logic [SLOTS-1:0] first_m, first_z, ge_m, ge_z;
	logic        out_free, found_m, found_z, bad, emit;
	logic [7:0]  hit_task, hit_event;
	logic [31:0] hit_rem;
	logic [7:0]  tick_delta;
	logic [10:0] ms_sum;

	// chain of timer cells; each takes its upper neighbor's entry on a shift
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [7:0]  n_task, n_event;
		logic [31:0] n_rem;
		if (i == SLOTS - 1) begin : g_end
			assign n_task  = 8'd0;
			assign n_event = 8'd0;
			assign n_rem   = 32'd0;
		end else begin : g_mid
			assign n_task  = c_task[i+1];
			assign n_event = c_event[i+1];
			assign n_rem   = c_rem[i+1];
		end
		ett_cell u_cell (
			.clk(clk), .ctrl(ctrl[i]), .key_task(task_q), .key_event(event_q),
			.wr_rem(tmo_q), .delta(delta_q), .nxt_task(n_task), .nxt_event(n_event),
			.nxt_rem(n_rem), .task_q(c_task[i]), .event_q(c_event[i]), .rem_q(c_rem[i]),
			.match(c_match[i]), .zero(c_zero[i])
		);
		assign live[i] = (count_q > CNTW'(i));
		assign app[i]  = (count_q == CNTW'(i));
	end

	// first live match / first expired, and the cells at or above them
	always_comb begin
		first_m = (c_match & live) & (~(c_match & live) + SLOTS'(1));
		first_z = (c_zero & live) & (~(c_zero & live) + SLOTS'(1));
		ge_m    = ~(first_m - SLOTS'(1));
		ge_z    = ~(first_z - SLOTS'(1));
		found_m = |first_m;
		found_z = |first_z;
	end

	// read out the selected cell
	always_comb begin
		hit_task  = '0;
		hit_event = '0;
		hit_rem   = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (state_q == S_SCAN ? first_z[i] : first_m[i]) begin
				hit_task  = hit_task | c_task[i];
				hit_event = hit_event | c_event[i];
				hit_rem   = hit_rem | c_rem[i];
			end
		end
	end

	assign out_free = !ovld_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	// output register loads a new item this cycle
	assign emit = out_free && ((state_q == S_CMD) || (state_q == S_STAT) ||
		((state_q == S_SCAN) && found_z));

	assign bad = (op_q > OP_QUERY) || ({1'b0, task_q} >= task_limit_q) ||
		({1'b0, event_q} >= event_limit_q) ||
		(((op_q == OP_CREATE) || (op_q == OP_UPDATE)) && (tmo_q == 32'd0));

	assign tick_delta = in_ch.systick_now - last_tick_q;
	assign ms_sum     = {1'b0, ms_q} + {3'd0, tick_delta};

	// cell controls
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			ctrl[i] = '0;
			case (state_q)
				S_DEC: ctrl[i].dec = 1'b1;
				S_SCAN: ctrl[i].shift = found_z && out_free && ge_z[i];
				S_CMD: begin
					if (out_free && !bad) begin
						case (op_q)
							OP_CREATE: ctrl[i].load = found_m ? first_m[i] : app[i];
							OP_UPDATE: ctrl[i].load = first_m[i];
							OP_DELETE: ctrl[i].shift = found_m && ge_m[i];
							default: ctrl[i] = '0;
						endcase
					end
				end
				default: ctrl[i] = '0;
			endcase
		end
	end

	// sequencer, table count, uptime and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			task_limit_q  <= LIMIT_RESET;
			event_limit_q <= LIMIT_RESET;
			count_q       <= '0;
			last_tick_q   <= '0;
			ms_q          <= '0;
			sec_q         <= '0;
			total_q       <= '0;
			ovld_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TASK_LIMIT:  task_limit_q <= cfg_data;
					CFG_EVENT_LIMIT: event_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				ovld_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						op_q    <= in_ch.operation;
						task_q  <= in_ch.task_id;
						event_q <= in_ch.evt_id;
						tmo_q   <= in_ch.wait_ms;
						delta_q <= tick_delta;
						if (in_ch.operation != OP_TICK) begin
							state_q <= S_CMD;
						end else if (tick_delta == 8'd0) begin
							state_q <= S_STAT;
						end else begin
							last_tick_q <= in_ch.systick_now;
							total_q     <= total_q + {24'd0, tick_delta};
							if (ms_sum >= MS_PER_SEC) begin
								ms_q  <= 10'(ms_sum - MS_PER_SEC);
								sec_q <= sec_q + 32'd1;
							end else begin
								ms_q <= ms_sum[9:0];
							end
							state_q <= S_DEC;
						end
					end
				end
				S_CMD: begin
					if (out_free) begin
						olast_q  <= 1'b1;
						okind_q  <= KIND_REPLY;
						otask_q  <= task_q;
						oevent_q <= event_q;
						orem_q   <= (!bad && found_m && (op_q == OP_QUERY)) ? hit_rem : 32'd0;
						oms_q    <= '0;
						osec_q   <= '0;
						osys_q   <= '0;
						if (bad) begin
							ostat_q <= ST_BADARG;
						end else if (op_q == OP_CREATE) begin
							if (found_m) begin
								ostat_q <= ST_OK;
							end else if (count_q == CNTW'(SLOTS)) begin
								ostat_q <= ST_FULL;
							end else begin
								ostat_q <= ST_OK;
								count_q <= count_q + CNTW'(1);
							end
						end else if (!found_m) begin
							ostat_q <= ST_MISSING;
						end else begin
							ostat_q <= ST_OK;
							if (op_q == OP_DELETE) count_q <= count_q - CNTW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_DEC: state_q <= S_SCAN;
				S_SCAN: begin
					if (!found_z) begin
						state_q <= S_STAT;
					end else if (out_free) begin
						olast_q  <= 1'b0;
						okind_q  <= KIND_EXPIRED;
						otask_q  <= hit_task;
						oevent_q <= hit_event;
						orem_q   <= '0;
						ostat_q  <= ST_OK;
						oms_q    <= '0;
						osec_q   <= '0;
						osys_q   <= '0;
						count_q  <= count_q - CNTW'(1);
					end
				end
				S_STAT: begin
					if (out_free) begin
						olast_q  <= 1'b1;
						okind_q  <= KIND_CLOCK;
						otask_q  <= '0;
						oevent_q <= '0;
						orem_q   <= '0;
						ostat_q  <= ST_OK;
						oms_q    <= ms_q;
						osec_q   <= sec_q;
						osys_q   <= total_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = ovld_q;
	assign out_ch.result_kind  = okind_q;
	assign out_ch.task_id_out  = otask_q;
	assign out_ch.evt_id_out   = oevent_q;
	assign out_ch.remaining_ms = orem_q;
	assign out_ch.status       = ostat_q;
	assign out_ch.clock_ms     = oms_q;
	assign out_ch.clock_sec    = osec_q;
	assign out_ch.sysclock_ms  = osys_q;
	assign out_ch.last         = olast_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(SLOTS))
		else $error("timer count above table size");

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q < 10'd1000)
		else $error("millisecond part out of range");

	a_expire_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found_z && out_free) |=> count_q == $past(count_q) - CNTW'(1))
		else $error("expired timer not removed");

	a_scan_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found_z && out_free) |=> ovld_q && okind_q == KIND_EXPIRED)
		else $error("expired timer not reported");
endmodule
